@@ rtl/core/audio_sync_sample_compensation_core_macros.svh @@
// assertion macros shared by the checker
`ifndef AUDIO_SYNC_SAMPLE_COMPENSATION_CORE_MACROS_SVH
`define AUDIO_SYNC_SAMPLE_COMPENSATION_CORE_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// signal holds in the cycle after the condition
`define ASSC_HOLD(lbl, clk, rst_n, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

@@ rtl/core/assc_pkg.sv @@
package assc_pkg;

  // sequencer states
  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StChk    = 8'b0000_0010,
    StLoad   = 8'b0000_0100,
    StMulLo  = 8'b0000_1000,
    StMulHi  = 8'b0001_0000,
    StMulAcc = 8'b0010_0000,
    StPost   = 8'b0100_0000,
    StDone   = 8'b1000_0000
  } st_e;

  // products computed by the shared multiplier, in issue order
  typedef enum logic [6:0] {
    OpDecay = 7'b000_0001,
    OpAvg   = 7'b000_0010,
    OpCorr  = 7'b000_0100,
    OpLoX   = 7'b000_1000,
    OpLoQ   = 7'b001_0000,
    OpHiX   = 7'b010_0000,
    OpHiQ   = 7'b100_0000
  } op_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;
  localparam logic [CfgIdxW-1:0] CfgSyncToAudio = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgAvgCoef     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDiffThr     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgNosyncLimit = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSourceRate  = 3'd4;

  // datapath widths
  localparam int unsigned SumW = 48;
  localparam int unsigned MulW = 24;
  localparam int unsigned AccW = 64;

  // 1.0 in Q0.16
  localparam logic [16:0] CoefOne = 17'h1_0000;

  // floor(x / 100) = (x * RecipMul) >> RecipShift, exact for x below 14.1e6
  localparam logic [MulW-1:0] RecipMul   = 24'd10737419;
  localparam int unsigned     RecipShift = 30;

  // saturation bounds of the difference sum
  localparam logic [SumW-1:0] SumMax = 48'h7FFF_FFFF_FFFF;
  localparam logic [SumW-1:0] SumMin = 48'h8000_0000_0000;

endpackage

@@ rtl/core/audio_sync_sample_compensation_core.sv @@
// Audio clock drift compensation, one decoded frame per transfer.
// Input channel (in_valid_i/in_ready_o) carries the frame's sample count, the
// audio-minus-master clock difference (signed Q8.24 s) and its valid flag.
// Output channel (out_valid_o/out_ready_i) returns one result per frame: the
// sample count the resampler should produce and a flag set when corrected.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must
// write them only while idle, which the block itself does not enforce. All
// products go through one 24x24 multiplier, each product taken as two 24-bit
// halves; a product passes load, two halves, add and use in that order.
// A frame uses no product for audio master or a rejected difference, one
// during warm-up, two below the threshold and all seven for a correction.
// The next frame is taken after the result moves to the output register.
// A result waiting on a stalled receiver keeps the block from finishing the
// next frame, but that frame is still taken and worked on up to the end.
// Reset restores the register defaults, clears the difference sum and the
// warm-up count and empties the output register.
module audio_sync_sample_compensation_core #(
  parameter int unsigned AVG_FRAMES         = 20,
  parameter int unsigned CORRECTION_PERCENT = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [assc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [assc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [15:0]                    frame_samples_i,
  input  logic signed [31:0]             clock_diff_i,
  input  logic                           diff_valid_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [16:0]                    wanted_samples_o,
  output logic                           corrected_o
);

  localparam int unsigned WarmW = $clog2(AVG_FRAMES + 1);
  localparam logic [WarmW-1:0] WarmLast = WarmW'(AVG_FRAMES);
  localparam logic [assc_pkg::MulW-1:0] LoPct = 24'(100 - CORRECTION_PERCENT);
  localparam logic [assc_pkg::MulW-1:0] HiPct = 24'(100 + CORRECTION_PERCENT);

  // configuration registers
  logic        sync_q;
  logic [15:0] coef_q;
  logic [30:0] thr_q;
  logic [30:0] nosync_q;
  logic [18:0] rate_q;

  // control state
  assc_pkg::st_e state_q, state_d;
  assc_pkg::op_e op_q, op_d;
  logic [assc_pkg::SumW-1:0] sum_q, sum_d;
  logic [WarmW-1:0] warm_q, warm_d;
  logic out_valid_q, out_valid_d;

  // payload
  logic [15:0] n_q, n_d;
  logic [31:0] diff_q, diff_d;
  logic        dvalid_q, dvalid_d;
  logic [31:0] dmag_q, dmag_d;
  logic [assc_pkg::SumW-1:0] opa_q, opa_d;
  logic [assc_pkg::MulW-1:0] opb_q, opb_d;
  logic [2*assc_pkg::MulW-1:0] mul_q, mul_d;
  logic [assc_pkg::AccW-1:0] acc_q, acc_d;
  logic [27:0] w_q, w_d;
  logic [assc_pkg::MulW-1:0] x_q, x_d;
  logic [16:0] lo_q, lo_d;
  logic [16:0] res_wanted_q, res_wanted_d;
  logic        res_corr_q, res_corr_d;
  logic [16:0] out_wanted_q, out_wanted_d;
  logic        out_corr_q, out_corr_d;

  // datapath helpers
  logic [assc_pkg::MulW-1:0]   mul_a;
  logic [2*assc_pkg::MulW-1:0] mul_p;
  logic [assc_pkg::SumW-1:0]   sum_mag;
  logic [31:0]                 dmag_c;
  logic [assc_pkg::SumW-1:0]   acc_hi;
  logic [assc_pkg::SumW:0]     pm_s;
  logic [assc_pkg::SumW:0]     sum_raw;
  logic [assc_pkg::SumW-1:0]   sum_sat;
  logic                        thr_hit;
  logic [25:0]                 cm;
  logic [27:0]                 w_c;
  logic [16:0]                 quot;
  logic [16:0]                 clip;

  assign in_ready_o       = (state_q == assc_pkg::StIdle);
  assign out_valid_o      = out_valid_q;
  assign wanted_samples_o = out_wanted_q;
  assign corrected_o      = out_corr_q;

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q   <= 1'b1;
      coef_q   <= 16'd52057;
      thr_q    <= 31'd779126;
      nosync_q <= 31'd167772160;
      rate_q   <= 19'd44100;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        assc_pkg::CfgSyncToAudio: sync_q   <= cfg_wdata_i[0];
        assc_pkg::CfgAvgCoef:     coef_q   <= cfg_wdata_i[15:0];
        assc_pkg::CfgDiffThr:     thr_q    <= cfg_wdata_i[30:0];
        assc_pkg::CfgNosyncLimit: nosync_q <= cfg_wdata_i[30:0];
        assc_pkg::CfgSourceRate:  rate_q   <= cfg_wdata_i[18:0];
        default: ;
      endcase
    end
  end

  // shared multiplier, low or high half of operand a
  assign mul_a = (state_q == assc_pkg::StMulHi) ? opa_q[47:24] : opa_q[23:0];
  assign mul_p = mul_a * opb_q;

  // magnitudes
  assign sum_mag = sum_q[47] ? (~sum_q + 48'd1) : sum_q;
  assign dmag_c  = diff_q[31] ? (~diff_q + 32'd1) : diff_q;

  // decayed sum plus new difference, saturated to 48 bits
  assign acc_hi  = acc_q[63:16];
  assign pm_s    = sum_q[47] ? (~{1'b0, acc_hi} + 49'd1) : {1'b0, acc_hi};
  assign sum_raw = pm_s + {{17{diff_q[31]}}, diff_q};
  always_comb begin
    if (sum_raw[48] != sum_raw[47]) begin
      sum_sat = sum_raw[48] ? assc_pkg::SumMin : assc_pkg::SumMax;
    end else begin
      sum_sat = sum_raw[47:0];
    end
  end

  // averaged magnitude against threshold
  assign thr_hit = (acc_hi >= {17'd0, thr_q});

  // count plus or minus the correction in samples
  assign cm  = acc_q[49:24];
  assign w_c = diff_q[31] ? ({12'd0, n_q} - {2'd0, cm}) : ({12'd0, n_q} + {2'd0, cm});

  // division by 100 through the reciprocal product
  assign quot = acc_q[assc_pkg::RecipShift +: 17];

  // clip to the lower then the upper bound
  always_comb begin
    if ($signed(w_q) < $signed({11'd0, lo_q})) begin
      clip = lo_q;
    end else if ($signed(w_q) > $signed({11'd0, quot})) begin
      clip = quot;
    end else begin
      clip = w_q[16:0];
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    sum_d        = sum_q;
    warm_d       = warm_q;
    out_valid_d  = out_valid_q;
    n_d          = n_q;
    diff_d       = diff_q;
    dvalid_d     = dvalid_q;
    dmag_d       = dmag_q;
    opa_d        = opa_q;
    opb_d        = opb_q;
    mul_d        = mul_q;
    acc_d        = acc_q;
    w_d          = w_q;
    x_d          = x_q;
    lo_d         = lo_q;
    res_wanted_d = res_wanted_q;
    res_corr_d   = res_corr_q;
    out_wanted_d = out_wanted_q;
    out_corr_d   = out_corr_q;

    // receiver takes the result
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      assc_pkg::StIdle: begin
        if (in_valid_i) begin
          n_d      = frame_samples_i;
          diff_d   = clock_diff_i;
          dvalid_d = diff_valid_i;
          state_d  = assc_pkg::StChk;
        end
      end
      assc_pkg::StChk: begin
        dmag_d       = dmag_c;
        res_wanted_d = {1'b0, n_q};
        res_corr_d   = 1'b0;
        if (sync_q) begin
          state_d = assc_pkg::StDone;
        end else if (!dvalid_q || (dmag_c >= {1'b0, nosync_q})) begin
          sum_d   = '0;
          warm_d  = '0;
          state_d = assc_pkg::StDone;
        end else begin
          op_d    = assc_pkg::OpDecay;
          state_d = assc_pkg::StLoad;
        end
      end
      assc_pkg::StLoad: begin
        case (op_q)
          assc_pkg::OpDecay: begin
            opa_d = sum_mag;
            opb_d = {8'd0, coef_q};
          end
          assc_pkg::OpAvg: begin
            opa_d = sum_mag;
            opb_d = {7'd0, assc_pkg::CoefOne - {1'b0, coef_q}};
          end
          assc_pkg::OpCorr: begin
            opa_d = {16'd0, dmag_q};
            opb_d = {5'd0, rate_q};
          end
          assc_pkg::OpLoX: begin
            opa_d = {32'd0, n_q};
            opb_d = LoPct;
          end
          assc_pkg::OpHiX: begin
            opa_d = {32'd0, n_q};
            opb_d = HiPct;
          end
          default: begin
            opa_d = {24'd0, x_q};
            opb_d = assc_pkg::RecipMul;
          end
        endcase
        state_d = assc_pkg::StMulLo;
      end
      assc_pkg::StMulLo: begin
        mul_d   = mul_p;
        state_d = assc_pkg::StMulHi;
      end
      assc_pkg::StMulHi: begin
        mul_d   = mul_p;
        acc_d   = {16'd0, mul_q};
        state_d = assc_pkg::StMulAcc;
      end
      assc_pkg::StMulAcc: begin
        acc_d   = acc_q + {mul_q[39:0], 24'd0};
        state_d = assc_pkg::StPost;
      end
      assc_pkg::StPost: begin
        state_d = assc_pkg::StLoad;
        case (op_q)
          assc_pkg::OpDecay: begin
            sum_d = sum_sat;
            if (warm_q < WarmLast) begin
              warm_d  = warm_q + WarmW'(1);
              state_d = assc_pkg::StDone;
            end else begin
              op_d = assc_pkg::OpAvg;
            end
          end
          assc_pkg::OpAvg: begin
            if (thr_hit) begin
              op_d = assc_pkg::OpCorr;
            end else begin
              state_d = assc_pkg::StDone;
            end
          end
          assc_pkg::OpCorr: begin
            w_d  = w_c;
            op_d = assc_pkg::OpLoX;
          end
          assc_pkg::OpLoX: begin
            x_d  = acc_q[23:0];
            op_d = assc_pkg::OpLoQ;
          end
          assc_pkg::OpLoQ: begin
            lo_d = quot;
            op_d = assc_pkg::OpHiX;
          end
          assc_pkg::OpHiX: begin
            x_d  = acc_q[23:0];
            op_d = assc_pkg::OpHiQ;
          end
          default: begin
            res_wanted_d = clip;
            res_corr_d   = 1'b1;
            state_d      = assc_pkg::StDone;
          end
        endcase
      end
      assc_pkg::StDone: begin
        // move the result once the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_wanted_d = res_wanted_q;
          out_corr_d   = res_corr_q;
          state_d      = assc_pkg::StIdle;
        end
      end
      default: state_d = assc_pkg::StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= assc_pkg::StIdle;
      op_q        <= assc_pkg::OpDecay;
      sum_q       <= '0;
      warm_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      sum_q       <= sum_d;
      warm_q      <= warm_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    n_q          <= n_d;
    diff_q       <= diff_d;
    dvalid_q     <= dvalid_d;
    dmag_q       <= dmag_d;
    opa_q        <= opa_d;
    opb_q        <= opb_d;
    mul_q        <= mul_d;
    acc_q        <= acc_d;
    w_q          <= w_d;
    x_q          <= x_d;
    lo_q         <= lo_d;
    res_wanted_q <= res_wanted_d;
    res_corr_q   <= res_corr_d;
    out_wanted_q <= out_wanted_d;
    out_corr_q   <= out_corr_d;
  end

endmodule

@@ rtl/core/assc_chk.sv @@
`include "audio_sync_sample_compensation_core_macros.svh"

module assc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [16:0] wanted_samples_o,
  input logic        corrected_o
);

  logic        in_xfer;
  logic        out_stall;
  logic [17:0] out_word;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign out_word  = {wanted_samples_o, corrected_o};

  // one frame at a time: busy right after an input transfer
  `ASSC_ASSERT(a_busy_after_in, clk_i, rst_ni, in_xfer |=> !in_ready_o, "ready after transfer")

  // a result never appears in the cycle after its frame is taken
  `ASSC_ASSERT(a_no_early_out, clk_i, rst_ni, in_xfer |=> !$rose(out_valid_o), "result too early")

  // a new result leaves the block idle
  `ASSC_ASSERT(a_idle_on_out, clk_i, rst_ni, $rose(out_valid_o) |-> in_ready_o, "busy on result")

  // stalled result stays
  `ASSC_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o, "result dropped")
  `ASSC_HOLD(a_out_stable, clk_i, rst_ni, out_stall, out_word, "result changed")

endmodule

bind audio_sync_sample_compensation_core assc_chk u_assc_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .wanted_samples_o (wanted_samples_o),
  .corrected_o      (corrected_o)
);
